### rtl/wvc_pkg.sv
// Shared types, constants and fp32 helper functions for the vertex batch cull unit.
`default_nettype none
package wvc_pkg;

  localparam int unsigned NumRegs = 8;
  localparam logic [5:0] AllPlanes = 6'((1 << 6) - 1);
  localparam logic [5:0] PlaneLeft = 6'(1 << 0);
  localparam logic [5:0] PlaneRight = 6'(1 << 1);
  localparam logic [5:0] PlaneBottom = 6'(1 << 2);
  localparam logic [5:0] PlaneTop = 6'(1 << 3);
  localparam logic [5:0] PlaneNear = 6'(1 << 4);
  localparam logic [5:0] PlaneFar = 6'(1 << 5);

  typedef struct packed {
    logic [31:0] vertex_x;
    logic [31:0] vertex_y;
    logic [31:0] vertex_z;
    logic        last_vertex;
  } vtx_in_t;

  typedef struct packed {
    logic       may_be_visible;
    logic [5:0] common_planes;
    logic       failed_open;
  } cull_out_t;

  // matrix element [row][col], fp32 bits
  typedef logic [3:0][3:0][31:0] mat_t;

  // products [col][row] handed from front to back
  typedef struct packed {
    logic [3:0][2:0][31:0] prod;
    logic                  bad;
    logic                  last;
  } wvc_item_t;

  // unrounded result: leading one at bit 47 means biased exponent e
  typedef struct packed {
    logic               sign;
    logic               zsign;
    logic signed [11:0] e;
    logic [47:0]        m;
  } fp_mid_t;

  function automatic logic fp_finite(logic [31:0] b);
    return b[30:23] != 8'hFF;
  endfunction

  // Returns {overflow, fp32 bits}, round to nearest even, subnormals kept.
  function automatic logic [32:0] fp_round(fp_mid_t x);
    logic [5:0]         lz;
    logic [47:0]        mn;
    logic signed [11:0] en;
    logic signed [11:0] sh;
    logic [5:0]         shu;
    logic [47:0]        ms;
    logic               lost;
    logic [7:0]         expf;
    logic               ovf;
    logic               g;
    logic               st;
    logic [30:0]        packed_v;
    logic [30:0]        sum;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (x.m[i]) lz = 6'(47 - i);
    end
    mn = x.m << lz;
    en = x.e - $signed({6'd0, lz});
    ovf = 1'b0;
    if (en >= 12'sd1) begin
      shu = 6'd0;
      expf = en[7:0];
      if (en > 12'sd254) ovf = 1'b1;
    end else begin
      sh = 12'sd1 - en;
      shu = (sh > 12'sd48) ? 6'd48 : sh[5:0];
      expf = 8'd0;
    end
    ms = mn >> shu;
    lost = |(mn & ~({48{1'b1}} << shu));
    g = ms[23];
    st = (|ms[22:0]) | lost;
    packed_v = {expf, ms[46:24]};
    sum = packed_v + 31'(g & (st | ms[24]));
    if (sum[30:23] == 8'hFF) ovf = 1'b1;
    if (x.m == 48'd0) return {1'b0, x.zsign, 31'd0};
    return {ovf, x.sign, sum};
  endfunction

  function automatic fp_mid_t fp_mul_mid(logic [31:0] a, logic [31:0] b);
    fp_mid_t    r;
    logic [7:0] ea;
    logic [7:0] eb;
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    r.sign = a[31] ^ b[31];
    r.zsign = a[31] ^ b[31];
    r.e = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
    r.m = {a[30:23] != 8'd0, a[22:0]} * {b[30:23] != 8'd0, b[22:0]};
    return r;
  endfunction

  function automatic fp_mid_t fp_add_mid(logic [31:0] a, logic [31:0] b);
    fp_mid_t     r;
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eb;
    logic [7:0]  es;
    logic [7:0]  diff;
    logic [5:0]  dsh;
    logic [47:0] mb;
    logic [47:0] mfull;
    logic [47:0] ms;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    diff = eb - es;
    dsh = (diff > 8'd48) ? 6'd48 : diff[5:0];
    mb = {1'b0, big[30:23] != 8'd0, big[22:0], 23'd0};
    mfull = {1'b0, sml[30:23] != 8'd0, sml[22:0], 23'd0};
    ms = mfull >> dsh;
    ms[0] = ms[0] | (|(mfull & ~({48{1'b1}} << dsh)));
    r.sign = big[31];
    r.zsign = a[31] & b[31];
    r.e = $signed({4'd0, eb}) + 12'sd1;
    r.m = (a[31] == b[31]) ? (mb + ms) : (mb - ms);
    return r;
  endfunction

  // a < b for finite values, zeros of either sign equal
  function automatic logic fp_lt(logic [31:0] a, logic [31:0] b);
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

endpackage
`default_nettype wire

### rtl/wvc_front.sv
// Front end: vertex accept, finiteness check and the twelve rounded products.
`default_nettype none
module wvc_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wvc_pkg::mat_t       mat_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wvc_pkg::vtx_in_t    in_data_i,
  output logic                item_valid_o,
  input  wire                 item_ready_i,
  output wvc_pkg::wvc_item_t  item_o
);

  logic                                 en;
  logic                                 v1_q, v2_q;
  logic                                 bad1_q, last1_q;
  wvc_pkg::fp_mid_t [3:0][2:0]          mid_d, mid_q;
  logic                                 bad_d;
  logic [2:0][31:0]                     vtx;
  wvc_pkg::wvc_item_t                   item_d, item_q;

  assign en = !v2_q || item_ready_i;
  assign in_ready_o = en;
  assign vtx = {in_data_i.vertex_z, in_data_i.vertex_y, in_data_i.vertex_x};

  always_comb begin
    bad_d = 1'b0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (!wvc_pkg::fp_finite(mat_i[r][c])) bad_d = 1'b1;
      end
    end
    for (int r = 0; r < 3; r++) begin
      if (!wvc_pkg::fp_finite(vtx[r])) bad_d = 1'b1;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        mid_d[c][r] = wvc_pkg::fp_mul_mid(vtx[r], mat_i[r][c]);
      end
    end
  end

  always_comb begin
    logic [32:0] rr;
    item_d.bad = bad1_q;
    item_d.last = last1_q;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        rr = wvc_pkg::fp_round(mid_q[c][r]);
        item_d.prod[c][r] = rr[31:0];
        if (rr[32]) item_d.bad = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mid_q <= mid_d;
      bad1_q <= bad_d;
      last1_q <= in_data_i.last_vertex;
      item_q <= item_d;
    end
  end

  assign item_valid_o = v2_q;
  assign item_o = item_q;

endmodule
`default_nettype wire

### rtl/wvc_queue.sv
// Small FIFO between the product front end and the summing back end.
`default_nettype none
module wvc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_valid_i,
  output logic                push_ready_o,
  input  wvc_pkg::wvc_item_t  push_data_i,
  output logic                pop_valid_o,
  input  wire                 pop_ready_i,
  output wvc_pkg::wvc_item_t  pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  wvc_pkg::wvc_item_t mem_q [DEPTH];
  logic [AW-1:0]      wptr_q, rptr_q;
  logic [CW-1:0]      count_q;
  logic               push, pop;

  assign push_ready_o = count_q != CW'(DEPTH);
  assign pop_valid_o = count_q != '0;
  assign push = push_valid_i && push_ready_o;
  assign pop = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push) wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      if (pop) rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      if (push && !pop) count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end

  cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("queue count above depth");
  cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1) else $error("queue lost a push");
  cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> count_q == $past(count_q) - 1'b1) else $error("queue lost a pop");

endmodule
`default_nettype wire

### rtl/wvc_back.sv
// Back end: three rounded sums per clip column, outcode, batch accumulation, result register.
`default_nettype none
module wvc_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire [3:0][31:0]     row3_i,
  input  wire                 item_valid_i,
  output logic                item_ready_o,
  input  wvc_pkg::wvc_item_t  item_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output wvc_pkg::cull_out_t  out_data_o
);

  logic                        en;
  logic [5:0]                  v_q;
  logic [5:0]                  bad_q, last_q;
  wvc_pkg::fp_mid_t [3:0]      m1_q, m3_q, m5_q;
  logic [3:0][31:0]            s2_q, s4_q, clip_q;
  logic [3:0][31:0]            p2a_q, p2b_q;
  logic [3:0][31:0]            s2_d, s4_d, clip_d;
  logic [2:0]                  ovf;
  logic [5:0]                  acc_q;
  logic                        nf_q;
  logic                        out_v_q;
  wvc_pkg::cull_out_t          out_q;
  logic [5:0]                  code, common_n;
  logic                        nf_n;
  logic [31:0]                 w, nw;
  logic                        fin;

  assign fin = v_q[5] && en;
  assign en = !(v_q[5] && last_q[5] && out_v_q && !out_ready_i);
  assign item_ready_o = en;

  always_comb begin
    logic [32:0] r2, r4, r6;
    ovf = '0;
    for (int c = 0; c < 4; c++) begin
      r2 = wvc_pkg::fp_round(m1_q[c]);
      r4 = wvc_pkg::fp_round(m3_q[c]);
      r6 = wvc_pkg::fp_round(m5_q[c]);
      s2_d[c] = r2[31:0];
      s4_d[c] = r4[31:0];
      clip_d[c] = r6[31:0];
      ovf[0] = ovf[0] | r2[32];
      ovf[1] = ovf[1] | r4[32];
      ovf[2] = ovf[2] | r6[32];
    end
  end

  // outcode against +-w
  always_comb begin
    w = clip_q[3];
    nw = {~w[31], w[30:0]};
    code = '0;
    if (wvc_pkg::fp_lt(clip_q[0], nw)) code = code | wvc_pkg::PlaneLeft;
    if (wvc_pkg::fp_lt(w, clip_q[0])) code = code | wvc_pkg::PlaneRight;
    if (wvc_pkg::fp_lt(clip_q[1], nw)) code = code | wvc_pkg::PlaneBottom;
    if (wvc_pkg::fp_lt(w, clip_q[1])) code = code | wvc_pkg::PlaneTop;
    if (wvc_pkg::fp_lt(clip_q[2], nw)) code = code | wvc_pkg::PlaneNear;
    if (wvc_pkg::fp_lt(w, clip_q[2])) code = code | wvc_pkg::PlaneFar;
    common_n = bad_q[5] ? acc_q : (acc_q & code);
    nf_n = nf_q || bad_q[5];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      acc_q <= wvc_pkg::AllPlanes;
      nf_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en) v_q <= {v_q[4:0], item_valid_i};
      if (out_ready_i) out_v_q <= 1'b0;
      if (fin) begin
        if (last_q[5]) begin
          acc_q <= wvc_pkg::AllPlanes;
          nf_q <= 1'b0;
          out_v_q <= 1'b1;
        end else begin
          acc_q <= common_n;
          nf_q <= nf_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bad_q <= {bad_q[4] | ovf[2], bad_q[3], bad_q[2] | ovf[1], bad_q[1],
                bad_q[0] | ovf[0], item_i.bad};
      last_q <= {last_q[4:0], item_i.last};
      for (int c = 0; c < 4; c++) begin
        m1_q[c] <= wvc_pkg::fp_add_mid(item_i.prod[c][0], item_i.prod[c][1]);
        p2a_q[c] <= item_i.prod[c][2];
        m3_q[c] <= wvc_pkg::fp_add_mid(s2_q[c], p2b_q[c]);
        m5_q[c] <= wvc_pkg::fp_add_mid(s4_q[c], row3_i[c]);
      end
      s2_q <= s2_d;
      p2b_q <= p2a_q;
      s4_q <= s4_d;
      clip_q <= clip_d;
    end
    if (fin && last_q[5]) begin
      if (nf_n) begin
        out_q.may_be_visible <= 1'b1;
        out_q.common_planes <= '0;
        out_q.failed_open <= 1'b1;
      end else begin
        out_q.may_be_visible <= common_n == '0;
        out_q.common_planes <= common_n;
        out_q.failed_open <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

  acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && last_q[5]) |=> (acc_q == wvc_pkg::AllPlanes && !nf_q && out_v_q))
    else $error("batch state not cleared after result");
  nf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && !last_q[5] && bad_q[5]) |=> nf_q) else $error("non-finite flag lost");
  cull_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.may_be_visible) |-> (out_q.common_planes != '0 && !out_q.failed_open))
    else $error("culled result without a common plane");

endmodule
`default_nettype wire

### rtl/world_vertex_batch_frustum_cull_unit.sv
// Top level: matrix registers, product front end, queue and summing back end.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o  | vtx_in_t (x, y, z, last flag)
//   out     | output    | out_valid_o / out_ready_i| cull_out_t, one per batch
//   cfg     | input     | cfg_we_i, no wait        | cfg_idx_i, cfg_wdata_i (64 bit)
//
// One vertex per clock while nothing stalls; the front end registers the products,
// then the rounded products; the queue and three add-and-round steps per column follow.
// Reset clears the matrix to zero, the batch code to all ones and all pipeline valids.
// The front stalls only on a full queue; the back stalls only when a batch result
// meets an output register that has not been taken.
`default_nettype none
module world_vertex_batch_frustum_cull_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [3:0]           cfg_idx_i,
  input  wire [63:0]          cfg_wdata_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wvc_pkg::vtx_in_t    in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output wvc_pkg::cull_out_t  out_data_o
);

  logic [wvc_pkg::NumRegs-1:0][63:0] mat_q;
  wvc_pkg::mat_t                     mat;
  logic                              f_valid, f_ready, q_valid, q_ready;
  wvc_pkg::wvc_item_t                f_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= '0;
    end else if (cfg_we_i && cfg_idx_i < 4'(wvc_pkg::NumRegs)) begin
      mat_q[cfg_idx_i[2:0]] <= cfg_wdata_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat[r][0] = mat_q[2*r][31:0];
      mat[r][1] = mat_q[2*r][63:32];
      mat[r][2] = mat_q[2*r+1][31:0];
      mat[r][3] = mat_q[2*r+1][63:32];
    end
  end

  wvc_front u_front (
    .clk_i, .rst_ni,
    .mat_i(mat),
    .in_valid_i, .in_ready_o, .in_data_i,
    .item_valid_o(f_valid), .item_ready_i(f_ready), .item_o(f_item)
  );

  wvc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready), .push_data_i(f_item),
    .pop_valid_o(q_valid), .pop_ready_i(q_ready), .pop_data_o(q_item)
  );

  wvc_back u_back (
    .clk_i, .rst_ni,
    .row3_i(mat[3]),
    .item_valid_i(q_valid), .item_ready_o(q_ready), .item_i(q_item),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
`default_nettype wire
